### rtl/core/frt_pkg.sv
// Shared types, constants and codes for the fragment reassembly tracker.
package frt_pkg;

    localparam int CONTEXTS      = 8;
    localparam int MAX_FRAGMENTS = 64;
    localparam int SLOT_W        = $clog2(CONTEXTS);
    localparam int SEQ_IDX_W     = $clog2(MAX_FRAGMENTS);
    localparam int EXP_W         = $clog2(MAX_FRAGMENTS + 1);
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0]  TIMEOUT_RESET = 8'd30;
    localparam logic [15:0] LIMIT_RESET   = 16'hFFFF;
    localparam logic [7:0]  AGE_MAX       = 8'hFF;

    localparam logic [1:0] MODE_FRAGMENT = 2'd0;
    localparam logic [1:0] MODE_TICK     = 2'd1;
    localparam logic [1:0] MODE_CLEAR    = 2'd2;

    localparam logic REG_TIMEOUT = 1'b0;
    localparam logic REG_LIMIT   = 1'b1;

    typedef enum logic [1:0] {
        OP_FRAGMENT,
        OP_TICK,
        OP_CLEAR,
        OP_NONE
    } op_t;

    typedef enum logic [3:0] {
        ST_WAITING        = 4'd0,
        ST_COMPLETE       = 4'd1,
        ST_DUPLICATE      = 4'd2,
        ST_NO_CONTEXT     = 4'd3,
        ST_CANNOT_CREATE  = 4'd4,
        ST_COUNT_MISMATCH = 4'd5,
        ST_BAD_SEQUENCE   = 4'd6,
        ST_OVERFLOW       = 4'd7,
        ST_DONE           = 4'd8
    } status_t;

    // Classified descriptor as it travels from the front end to the table.
    typedef struct packed {
        op_t         op;
        logic [15:0] packet_id;
        logic [15:0] sequence_number;
        logic [15:0] total_count;
        logic        first_flag;
        logic [15:0] payload_length;
        logic        count_ok;   // total count is a legal size for a new context
        logic        seq_ok;     // sequence number lies below the total count
    } cmd_t;

    // Handshake between front end and queue.
    typedef struct packed {
        logic push;
        logic full;
    } push_ctl_t;

endpackage

### rtl/core/frt_front.sv
// Front end: input handshake and descriptor classification.
module frt_front (
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_mode,
    input  logic [15:0]      s_packet_id,
    input  logic [15:0]      s_sequence_number,
    input  logic [15:0]      s_total_count,
    input  logic             s_first_flag,
    input  logic [15:0]      s_payload_length,
    input  logic             q_full,
    output frt_pkg::push_ctl_t push_ctl,
    output frt_pkg::cmd_t    cmd
);
    import frt_pkg::*;

    assign s_ready       = !q_full;
    assign push_ctl.push = s_valid && !q_full;
    assign push_ctl.full = q_full;

    always_comb begin
        unique case (s_mode)
            MODE_FRAGMENT: cmd.op = OP_FRAGMENT;
            MODE_TICK:     cmd.op = OP_TICK;
            MODE_CLEAR:    cmd.op = OP_CLEAR;
            default:       cmd.op = OP_NONE;
        endcase
        cmd.packet_id       = s_packet_id;
        cmd.sequence_number = s_sequence_number;
        cmd.total_count     = s_total_count;
        cmd.first_flag      = s_first_flag;
        cmd.payload_length  = s_payload_length;
        cmd.count_ok        = (s_total_count != 16'd0) &&
                              (s_total_count <= 16'(MAX_FRAGMENTS));
        cmd.seq_ok          = s_sequence_number < s_total_count;
    end

endmodule

### rtl/core/frt_queue.sv
// Short descriptor queue between the front end and the context table.
module frt_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  frt_pkg::push_ctl_t push_ctl,
    input  frt_pkg::cmd_t      push_data,
    output logic               full,
    output logic               q_valid,
    output frt_pkg::cmd_t      q_data,
    input  logic               q_pop
);
    import frt_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_pop;

    assign full    = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign q_valid = count_reg != '0;
    assign q_data  = entry_reg[rd_ptr_reg];
    assign do_pop  = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_ctl.push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_ctl.push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push_ctl.push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_ctl.push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/core/frt_back.sv
// Back end: context table, per-descriptor update and result register.
module frt_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_valid,
    input  frt_pkg::cmd_t q_data,
    output logic          q_pop,
    input  logic [7:0]    timeout_ticks,
    input  logic [15:0]   buffer_limit,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [3:0]    m_status,
    output logic [2:0]    m_slot,
    output logic [15:0]   m_write_offset,
    output logic [15:0]   m_total_bytes
);
    import frt_pkg::*;

    logic [CONTEXTS-1:0]      slot_valid_reg, slot_valid_next;
    logic [15:0]              slot_packet_id_reg [CONTEXTS];
    logic [15:0]              slot_packet_id_next [CONTEXTS];
    logic [EXP_W-1:0]         slot_expected_reg [CONTEXTS];
    logic [EXP_W-1:0]         slot_expected_next [CONTEXTS];
    logic [MAX_FRAGMENTS-1:0] slot_seen_map_reg [CONTEXTS];
    logic [MAX_FRAGMENTS-1:0] slot_seen_map_next [CONTEXTS];
    logic [EXP_W-1:0]         slot_received_reg [CONTEXTS];
    logic [EXP_W-1:0]         slot_received_next [CONTEXTS];
    logic [15:0]              slot_bytes_reg [CONTEXTS];
    logic [15:0]              slot_bytes_next [CONTEXTS];
    logic [7:0]               slot_age_reg [CONTEXTS];
    logic [7:0]               slot_age_next [CONTEXTS];

    logic                     m_valid_reg;
    status_t                  status_reg, status_next;
    logic [2:0]               slot_reg, slot_next;
    logic [15:0]              offset_reg, offset_next;
    logic [15:0]              total_reg, total_next;

    logic [CONTEXTS-1:0]      live;
    logic [CONTEXTS-1:0]      hit;
    logic                     hit_any, free_any, create;
    logic [SLOT_W-1:0]        hit_idx, free_idx, sel;
    logic [15:0]              held;
    logic [MAX_FRAGMENTS-1:0] cur_map;
    logic [EXP_W-1:0]         cur_exp, recv_inc;
    logic [16:0]              sum;
    logic [SEQ_IDX_W-1:0]     seq_idx;

    assign q_pop = q_valid && (!m_valid_reg || m_ready);
    assign seq_idx = q_data.sequence_number[SEQ_IDX_W-1:0];

    // Expire, then match by id and look for a free slot; lowest index wins.
    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = 0; i < CONTEXTS; i++) begin
            live[i] = slot_valid_reg[i] && !(slot_age_reg[i] > timeout_ticks);
            hit[i]  = live[i] && (slot_packet_id_reg[i] == q_data.packet_id);
        end
        for (int i = CONTEXTS - 1; i >= 0; i--) begin
            if (hit[i]) begin
                hit_idx = SLOT_W'(i);
            end
            if (!live[i]) begin
                free_idx = SLOT_W'(i);
            end
        end
        hit_any  = |hit;
        free_any = !(&live);
        sel      = hit_any ? hit_idx : free_idx;
        create   = !hit_any && q_data.first_flag && free_any && q_data.count_ok;
        held     = create ? 16'd0 : slot_bytes_reg[sel];
        cur_map  = create ? '0 : slot_seen_map_reg[sel];
        cur_exp  = create ? q_data.total_count[EXP_W-1:0] : slot_expected_reg[sel];
        recv_inc = (create ? '0 : slot_received_reg[sel]) + 1'b1;
        sum      = {1'b0, held} + {1'b0, q_data.payload_length};
    end

    always_comb begin
        slot_valid_next     = slot_valid_reg;
        slot_packet_id_next = slot_packet_id_reg;
        slot_expected_next  = slot_expected_reg;
        slot_seen_map_next  = slot_seen_map_reg;
        slot_received_next  = slot_received_reg;
        slot_bytes_next     = slot_bytes_reg;
        slot_age_next       = slot_age_reg;
        status_next         = ST_DONE;
        slot_next           = 3'd0;
        offset_next         = 16'd0;
        total_next          = 16'd0;

        unique case (q_data.op)
            OP_FRAGMENT: begin
                slot_valid_next = live;
                priority if (!hit_any && !q_data.first_flag) begin
                    status_next = ST_NO_CONTEXT;
                end else if (!hit_any && !(free_any && q_data.count_ok)) begin
                    status_next = ST_CANNOT_CREATE;
                end else begin
                    if (create) begin
                        slot_valid_next[sel]     = 1'b1;
                        slot_packet_id_next[sel] = q_data.packet_id;
                        slot_expected_next[sel]  = q_data.total_count[EXP_W-1:0];
                        slot_seen_map_next[sel]  = '0;
                        slot_received_next[sel]  = '0;
                        slot_bytes_next[sel]     = 16'd0;
                        slot_age_next[sel]       = 8'd0;
                    end
                    slot_next  = 3'(sel);
                    total_next = held;
                    priority if (16'(cur_exp) != q_data.total_count) begin
                        status_next = ST_COUNT_MISMATCH;
                    end else if (!q_data.seq_ok) begin
                        status_next = ST_BAD_SEQUENCE;
                    end else if (cur_map[seq_idx]) begin
                        status_next = ST_DUPLICATE;
                        offset_next = held;
                    end else if (sum > {1'b0, buffer_limit}) begin
                        status_next          = ST_OVERFLOW;
                        slot_valid_next[sel] = 1'b0;
                    end else begin
                        slot_seen_map_next[sel] = cur_map |
                                                  (MAX_FRAGMENTS'(1) << seq_idx);
                        slot_bytes_next[sel]    = sum[15:0];
                        slot_received_next[sel] = recv_inc;
                        offset_next             = held;
                        total_next              = sum[15:0];
                        if (recv_inc == cur_exp) begin
                            status_next          = ST_COMPLETE;
                            slot_valid_next[sel] = 1'b0;
                        end else begin
                            status_next = ST_WAITING;
                        end
                    end
                end
            end
            OP_TICK: begin
                for (int i = 0; i < CONTEXTS; i++) begin
                    if (slot_valid_reg[i] && slot_age_reg[i] != AGE_MAX) begin
                        slot_age_next[i] = slot_age_reg[i] + 1'b1;
                    end
                end
            end
            OP_CLEAR: begin
                slot_valid_next = '0;
            end
            OP_NONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_valid_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (q_pop) begin
                slot_valid_reg <= slot_valid_next;
                m_valid_reg    <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            slot_packet_id_reg <= slot_packet_id_next;
            slot_expected_reg  <= slot_expected_next;
            slot_seen_map_reg  <= slot_seen_map_next;
            slot_received_reg  <= slot_received_next;
            slot_bytes_reg     <= slot_bytes_next;
            slot_age_reg       <= slot_age_next;
            status_reg         <= status_next;
            slot_reg           <= slot_next;
            offset_reg         <= offset_next;
            total_reg          <= total_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = status_reg;
    assign m_slot         = slot_reg;
    assign m_write_offset = offset_reg;
    assign m_total_bytes  = total_reg;

    a_pop_only_when_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (!m_valid_reg || m_ready))
        else $error("descriptor retired while result register is occupied");

    a_clear_frees_all: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_data.op == OP_CLEAR) |=> (slot_valid_reg == '0))
        else $error("clear left a context open");

    a_complete_frees_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_data.op == OP_FRAGMENT && status_next == ST_COMPLETE)
        |=> !slot_valid_reg[$past(sel)])
        else $error("completed context still open");

    a_result_follows_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> m_valid_reg)
        else $error("retired descriptor produced no result");

endmodule

### rtl/core/fragment_reassembly_tracker_top.sv
// Top level of the fragment reassembly tracker: config registers and datapath.
//
// Tracks up to eight open reassembly contexts. Every transfer on the s_
// channel (fragment descriptor, tick, or clear-all) yields exactly one result
// transfer on the m_ channel, in order. A front end classifies each transfer
// and drops it into a two-entry queue; the back end retires one descriptor
// per clock while the output register is free or m_ready is high, against
// the context table (expire, id match, create, count, sequence, duplicate
// and byte-limit checks, all combinational) and parks the answer in an
// output register. Sustained rate is one item per clock while m_ready is
// high. With no stall on the result side, an accepted s_ transfer goes into
// a queue entry and then into the result register, raising m_valid. A
// stalled result side fills the queue after two more items, and s_ready drops.
// Registers via the APB port: 0x0 timeout_ticks (reset 30), 0x4 buffer_limit
// (reset 65535); write them only while the block is idle.
module fragment_reassembly_tracker_top (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // descriptor transfers
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [15:0] s_packet_id,
    input  logic [15:0] s_sequence_number,
    input  logic [15:0] s_total_count,
    input  logic        s_first_flag,
    input  logic [15:0] s_payload_length,
    // result transfers
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_status,
    output logic [2:0]  m_slot,
    output logic [15:0] m_write_offset,
    output logic [15:0] m_total_bytes
);
    import frt_pkg::*;

    logic [7:0]  timeout_reg;
    logic [15:0] limit_reg;
    logic        cfg_write;

    push_ctl_t   push_ctl;
    cmd_t        front_cmd;
    cmd_t        q_data;
    logic        q_full;
    logic        q_valid;
    logic        q_pop;

    // Register select is address bit 2; the low byte-lane bits are ignored.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
            limit_reg   <= LIMIT_RESET;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_TIMEOUT: timeout_reg <= pwdata[7:0];
                REG_LIMIT:   limit_reg   <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_TIMEOUT: prdata = {24'd0, timeout_reg};
            REG_LIMIT:   prdata = {16'd0, limit_reg};
            default:     prdata = 32'd0;
        endcase
    end

    // Classify and push into the queue.
    frt_front u_front (
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_mode            (s_mode),
        .s_packet_id       (s_packet_id),
        .s_sequence_number (s_sequence_number),
        .s_total_count     (s_total_count),
        .s_first_flag      (s_first_flag),
        .s_payload_length  (s_payload_length),
        .q_full            (q_full),
        .push_ctl          (push_ctl),
        .cmd               (front_cmd)
    );

    // Hold classified descriptors so each side can stall on its own.
    frt_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_ctl  (push_ctl),
        .push_data (front_cmd),
        .full      (q_full),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop)
    );

    // Retire descriptors against the context table.
    frt_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_data         (q_data),
        .q_pop          (q_pop),
        .timeout_ticks  (timeout_reg),
        .buffer_limit   (limit_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_slot         (m_slot),
        .m_write_offset (m_write_offset),
        .m_total_bytes  (m_total_bytes)
    );

endmodule
